FILE: rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Needs nothing else; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Check a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/wsdf_pkg.sv
// Shared types and constants for the masked WebSocket frame deframer.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package wsdf_pkg;

   // Parser phase codes
   localparam logic [2:0] PH_FIRST  = 3'd0;
   localparam logic [2:0] PH_LEN    = 3'd1;
   localparam logic [2:0] PH_EXT_HI = 3'd2;
   localparam logic [2:0] PH_EXT_LO = 3'd3;
   localparam logic [2:0] PH_MASK   = 3'd4;
   localparam logic [2:0] PH_DATA   = 3'd5;

   // Result status codes
   localparam logic [2:0] ST_DATA       = 3'd0;
   localparam logic [2:0] ST_BAD_FIRST  = 3'd1;
   localparam logic [2:0] ST_NOT_MASKED = 3'd2;
   localparam logic [2:0] ST_LEN127     = 3'd3;
   localparam logic [2:0] ST_EMPTY      = 3'd4;
   localparam logic [2:0] ST_TOO_LARGE  = 3'd5;

   // Header constants
   localparam logic [7:0]  FIRST_BYTE     = 8'h82;
   localparam logic [6:0]  LEN_EXT16      = 7'd126;
   localparam logic [6:0]  LEN_EXT64      = 7'd127;
   localparam logic [16:0] OVERHEAD_SHORT = 17'd6;   // 2 header + 4 mask
   localparam logic [16:0] OVERHEAD_EXT   = 17'd8;   // 4 header + 4 mask
   localparam logic [16:0] MAX_LEN_RESET  = 17'd65543;

   // One result beat
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       last;
      logic [2:0] status;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/wsdf_parser.sv
// Frame header parser and payload unmasker: one received byte per beat.
// Uses wsdf_pkg and assert_macros.svh; feeds wsdf_rsp_buf.
`default_nettype none
`include "assert_macros.svh"

module wsdf_parser
   import wsdf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept_i,
   input  wire logic [7:0]  rx_byte_i,
   input  wire logic        csr_wr_en,
   input  wire logic [16:0] csr_wr_data,
   output rsp_type          res_o,
   output logic             res_valid_o
);

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] plen_ff, plen_in;
   logic        ext_ff, ext_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  idx_ff, idx_in;
   logic [15:0] left_ff, left_in;
   logic [16:0] max_len_ff;

   logic [6:0]  len7;
   logic [15:0] chk_len;
   logic        chk_ext;
   logic [16:0] total;
   logic        too_large;
   logic [7:0]  key_byte;

   // Size check operands: short length in the length byte, long one in the low ext byte
   always_comb begin
      len7 = rx_byte_i[6:0];
      if (phase_ff == PH_EXT_LO) begin
         chk_len = {plen_ff[15:8], rx_byte_i};
         chk_ext = 1'b1;
      end else begin
         chk_len = {9'd0, len7};
         chk_ext = 1'b0;
      end
      total     = {1'b0, chk_len} + (chk_ext ? OVERHEAD_EXT : OVERHEAD_SHORT);
      too_large = total > max_len_ff;
   end

   // Pick the mask byte for this payload position, first key byte first
   always_comb begin
      unique case (idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // Advance the parser on each accepted beat
   always_comb begin
      phase_in    = phase_ff;
      plen_in     = plen_ff;
      ext_in      = ext_ff;
      key_in      = key_ff;
      idx_in      = idx_ff;
      left_in     = left_ff;
      res_valid_o = 1'b0;
      res_o       = '0;
      if (accept_i) begin
         unique case (phase_ff)
            PH_LEN, PH_EXT_LO: begin
               if (phase_ff == PH_LEN && len7 == LEN_EXT64) begin
                  phase_in     = PH_FIRST;
                  res_valid_o  = 1'b1;
                  res_o.status = ST_LEN127;
               end else if (phase_ff == PH_LEN && !rx_byte_i[7]) begin
                  phase_in     = PH_FIRST;
                  res_valid_o  = 1'b1;
                  res_o.status = ST_NOT_MASKED;
               end else if (phase_ff == PH_LEN && len7 == LEN_EXT16) begin
                  ext_in   = 1'b1;
                  plen_in  = '0;
                  phase_in = PH_EXT_HI;
               end else begin
                  ext_in  = chk_ext;
                  plen_in = chk_len;
                  if (too_large) begin
                     phase_in     = PH_FIRST;
                     res_valid_o  = 1'b1;
                     res_o.status = ST_TOO_LARGE;
                  end else if (chk_len == 16'd0) begin
                     phase_in     = PH_FIRST;
                     res_valid_o  = 1'b1;
                     res_o.status = ST_EMPTY;
                  end else begin
                     key_in   = '0;
                     idx_in   = '0;
                     phase_in = PH_MASK;
                  end
               end
            end
            PH_EXT_HI: begin
               plen_in  = {rx_byte_i, 8'd0};
               phase_in = PH_EXT_LO;
            end
            PH_MASK: begin
               key_in = {key_ff[23:0], rx_byte_i};
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  left_in  = plen_ff;
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               idx_in             = idx_ff + 2'd1;
               left_in            = left_ff - 16'd1;
               res_valid_o        = 1'b1;
               res_o.payload_byte = rx_byte_i ^ key_byte;
               res_o.last         = (left_ff == 16'd1);
               res_o.status       = ST_DATA;
               if (left_ff == 16'd1) begin
                  phase_in = PH_FIRST;
               end
            end
            default: begin
               // Waiting for a first byte; unused codes land here too
               if (rx_byte_i != FIRST_BYTE) begin
                  phase_in     = PH_FIRST;
                  res_valid_o  = 1'b1;
                  res_o.status = ST_BAD_FIRST;
               end else begin
                  phase_in = PH_LEN;
               end
            end
         endcase
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         plen_ff  <= '0;
         ext_ff   <= 1'b0;
         key_ff   <= '0;
         idx_ff   <= '0;
         left_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         plen_ff  <= plen_in;
         ext_ff   <= ext_in;
         key_ff   <= key_in;
         idx_ff   <= idx_in;
         left_ff  <= left_in;
      end
   end

   // Frame size limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   `ASSERT_CLK(a_data_has_bytes, clock, reset, (phase_ff == PH_DATA) |-> (left_ff != 16'd0), "payload phase with no bytes left")
   `ASSERT_CLK(a_err_restarts, clock, reset, (res_valid_o && (res_o.status != ST_DATA || res_o.last)) |=> (phase_ff == PH_FIRST), "parser did not return to first byte after frame end or error")

endmodule

`default_nettype wire

FILE: rtl/wsdf_rsp_buf.sv
// Two-entry output buffer for result beats; parts input and result handshakes.
// Uses wsdf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module wsdf_rsp_buf
   import wsdf_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push_i,
   input  rsp_type   push_data_i,
   output logic      full_o,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output rsp_type   head_o
);

   rsp_type    head_ff, head_in;
   rsp_type    tail_ff, tail_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign full_o    = (cnt_ff == 2'd2);
   assign head_o    = head_ff;

   // Move beats: new beat goes to head when head frees, else to tail
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      priority if (cnt_ff == 2'd2) begin
         if (pop) begin
            head_in = tail_ff;
            cnt_in  = 2'd1;
         end
      end else if (cnt_ff == 2'd1) begin
         if (push_i && pop) begin
            head_in = push_data_i;
         end else if (push_i) begin
            tail_in = push_data_i;
            cnt_in  = 2'd2;
         end else if (pop) begin
            cnt_in = 2'd0;
         end
      end else begin
         if (push_i) begin
            head_in = push_data_i;
            cnt_in  = 2'd1;
         end
      end
   end

   // Hold buffer contents and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   `ASSERT_CLK(a_no_push_full, clock, reset, (cnt_ff == 2'd2) |-> !push_i, "beat pushed into full buffer")
   `ASSERT_CLK(a_tail_moves_up, clock, reset, (cnt_ff == 2'd2 && pop) |=> (head_ff == $past(tail_ff)), "buffered beat lost or reordered")

endmodule

`default_nettype wire

FILE: rtl/websocket_frame_deframer_unmask.sv
// Top level of the masked WebSocket binary frame deframer.
// Uses wsdf_pkg, wsdf_parser and wsdf_rsp_buf.
`default_nettype none

// Takes one stream byte per clock and returns at most one result beat per byte:
// header, extended-length and mask-key bytes give none, each payload byte gives
// its unmasked value (last set on the final one), and a header fault gives one
// error beat with zero data, after which the parser waits for a new 0x82 byte.
// Each byte is handled in the cycle it is accepted; its result is registered in a
// two-entry output buffer that drives rsp_valid, and the sustained rate is one
// byte per clock while rsp_stall stays low. req_stall rises only when both buffer
// entries are held by a stalled result side. csr_wr_data sets the largest total
// frame size (header, mask key and payload); write it only while idle.
module websocket_frame_deframer_unmask
   import wsdf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_last,
   output logic [2:0]       rsp_status,
   input  wire logic        csr_wr_en,
   input  wire logic [16:0] csr_wr_data
);

   logic    accept;
   logic    res_valid;
   logic    buf_full;
   rsp_type res;
   rsp_type head;

   // Take a beat whenever the buffer has room
   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   wsdf_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept_i    (accept),
      .rx_byte_i   (req_rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .res_o       (res),
      .res_valid_o (res_valid)
   );

   wsdf_rsp_buf u_rsp_buf (
      .clock       (clock),
      .reset       (reset),
      .push_i      (res_valid),
      .push_data_i (res),
      .full_o      (buf_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .head_o      (head)
   );

   assign rsp_payload_byte = head.payload_byte;
   assign rsp_last         = head.last;
   assign rsp_status       = head.status;

endmodule

`default_nettype wire

FILE: test/wsdf_checker.sv
// Checker for the masked WebSocket frame deframer: watches the byte and result channels,
// predicts each result beat and compares it field by field.
// Depends on wsdf_pkg for the status and phase codes and the result beat type.
module wsdf_checker
   import wsdf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_payload_byte,
   input  logic        rsp_last,
   input  logic [2:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data,
   input  logic        end_check,
   output int          fail_count,
   output int          beats_owed,
   output int          data_beats,
   output int          error_beats,
   output int          frames_closed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_CAP = 40;

   // Parser state tracked alongside the block
   logic [2:0]  phase_q;
   logic [15:0] frame_len_q;
   logic [16:0] overhead_q;
   logic [31:0] key_q;
   logic [1:0]  key_pos_q;
   logic [15:0] left_q;
   logic [16:0] size_limit_q;

   rsp_type pending_beats[$];
   bit      leftovers_done;

   initial begin
      fail_count = 0;
      beats_owed = 0;
      data_beats = 0;
      error_beats = 0;
      frames_closed = 0;
      leftovers_done = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [7:0] want,
                                  input logic [7:0] got);
      if (fail_count < PRINT_CAP)
         $display("%0t mismatch: %s, expected %h, got %h", $realtime, what, want, got);
      fail_count++;
   endtask

   // Reject oversize or empty frames; otherwise start collecting the mask key
   task automatic size_check(output bit produced, output rsp_type beat);
      logic [17:0] total;
      produced = 1'b0;
      beat = '0;
      total = frame_len_q + overhead_q;
      if (total > {1'b0, size_limit_q}) begin
         beat.status = ST_TOO_LARGE;
         produced = 1'b1;
         phase_q = PH_FIRST;
      end else if (frame_len_q == '0) begin
         beat.status = ST_EMPTY;
         produced = 1'b1;
         phase_q = PH_FIRST;
      end else begin
         key_q = '0;
         key_pos_q = '0;
         phase_q = PH_MASK;
      end
   endtask

   // Advance the parser by one received byte and form the beat it gives, if any
   task automatic unmask_byte(input logic [7:0] rx, output bit produced, output rsp_type beat);
      produced = 1'b0;
      beat = '0;
      case (phase_q)
         PH_LEN: begin
            if (rx[6:0] == LEN_EXT64) begin
               beat.status = ST_LEN127;
               produced = 1'b1;
               phase_q = PH_FIRST;
            end else if (!rx[7]) begin
               beat.status = ST_NOT_MASKED;
               produced = 1'b1;
               phase_q = PH_FIRST;
            end else if (rx[6:0] == LEN_EXT16) begin
               overhead_q = OVERHEAD_EXT;
               frame_len_q = '0;
               phase_q = PH_EXT_HI;
            end else begin
               overhead_q = OVERHEAD_SHORT;
               frame_len_q = {9'd0, rx[6:0]};
               size_check(produced, beat);
            end
         end
         PH_EXT_HI: begin
            frame_len_q = {rx, 8'h00};
            phase_q = PH_EXT_LO;
         end
         PH_EXT_LO: begin
            frame_len_q = frame_len_q | {8'h00, rx};
            size_check(produced, beat);
         end
         PH_MASK: begin
            key_q = {key_q[23:0], rx};
            key_pos_q = key_pos_q + 2'd1;
            if (key_pos_q == 2'd0) begin
               left_q = frame_len_q;
               phase_q = PH_DATA;
            end
         end
         PH_DATA: begin
            // first key byte applies to the first payload byte
            beat.payload_byte = rx ^ key_q[8 * (3 - key_pos_q) +: 8];
            key_pos_q = key_pos_q + 2'd1;
            left_q = left_q - 16'd1;
            beat.last = (left_q == 16'd0);
            if (beat.last)
               phase_q = PH_FIRST;
            produced = 1'b1;
         end
         default: begin
            // unknown codes fall back to waiting for a first byte
            if (rx != FIRST_BYTE) begin
               beat.status = ST_BAD_FIRST;
               produced = 1'b1;
               phase_q = PH_FIRST;
            end else begin
               phase_q = PH_LEN;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      bit      produced;
      rsp_type beat;
      rsp_type want;
      if (reset) begin
         phase_q = PH_FIRST;
         frame_len_q = '0;
         overhead_q = OVERHEAD_SHORT;
         key_q = '0;
         key_pos_q = '0;
         left_q = '0;
         size_limit_q = MAX_LEN_RESET;
         pending_beats.delete();
      end else begin
         if (csr_wr_en)
            size_limit_q = csr_wr_data;

         // compare an accepted result beat against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pending_beats.size() == 0) begin
               report_mismatch("result beat with nothing expected, status", 8'h00,
                               {5'd0, rsp_status});
            end else begin
               want = pending_beats.pop_front();
               if (rsp_payload_byte !== want.payload_byte)
                  report_mismatch("payload_byte", want.payload_byte, rsp_payload_byte);
               if (rsp_last !== want.last)
                  report_mismatch("last", {7'd0, want.last}, {7'd0, rsp_last});
               if (rsp_status !== want.status)
                  report_mismatch("status", {5'd0, want.status}, {5'd0, rsp_status});
               if (want.status == ST_DATA)
                  data_beats++;
               else
                  error_beats++;
               if (want.last)
                  frames_closed++;
            end
         end

         // predict the beat of an accepted input byte
         if (req_valid && !req_stall) begin
            unmask_byte(req_rx_byte, produced, beat);
            if (produced)
               pending_beats.push_back(beat);
         end

         // flag every prediction still waiting once the run has drained
         if (end_check && !leftovers_done) begin
            leftovers_done = 1'b1;
            while (pending_beats.size() != 0) begin
               want = pending_beats.pop_front();
               report_mismatch("result beat never arrived, status", {5'd0, want.status}, 8'h00);
            end
         end
      end
      beats_owed <= pending_beats.size();
   end

endmodule

FILE: test/websocket_frame_deframer_unmask_tb.sv
// Testbench top for the masked WebSocket frame deframer: drives byte streams, size limits
// and result-side stalls, and reports the verdict. Depends on wsdf_pkg, wsdf_checker and the RTL.
module websocket_frame_deframer_unmask_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wsdf_pkg::*;

   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam int          RANDOM_BYTES = 110;
   localparam logic [16:0] LIMIT_TOP    = 17'h1ffff;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_last;
   logic [2:0]  rsp_status;
   logic        csr_wr_en = 1'b0;
   logic [16:0] csr_wr_data = '0;
   logic        end_check = 1'b0;

   int fail_count;
   int beats_owed;
   int data_beats;
   int error_beats;
   int frames_closed;

   int          cycles = 0;
   int          bytes_sent = 0;
   int          limit_writes = 0;
   int          stall_left = 0;
   bit          calm = 1'b0;
   logic [16:0] cur_limit = MAX_LEN_RESET;
   logic [7:0]  opening [21];

   websocket_frame_deframer_unmask u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   wsdf_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .end_check        (end_check),
      .fail_count       (fail_count),
      .beats_owed       (beats_owed),
      .data_beats       (data_beats),
      .error_beats      (error_beats),
      .frames_closed    (frames_closed)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Stall the result side in bursts: mostly short, now and then long
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left == 0) begin
         if (rsp_stall) begin
            rsp_stall <= 1'b0;
            stall_left <= $urandom_range(1, 25);
         end else begin
            rsp_stall <= 1'b1;
            case ($urandom_range(0, 19))
               0:             stall_left <= $urandom_range(20, 60);
               1, 2, 3, 4:    stall_left <= $urandom_range(4, 10);
               default:       stall_left <= $urandom_range(1, 3);
            endcase
         end
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one byte, with an optional idle gap ahead, and hold it until taken
   task automatic push_byte(input logic [7:0] rx);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // Drain the block, then set a new frame size limit
   task automatic write_limit(input logic [16:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (beats_owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_limit = value;
      limit_writes++;
   endtask

   // Send a frame header; if the block will accept it, follow with key and payload
   task automatic send_frame(input int len, input bit ext, input int payload_cnt);
      int overhead;
      push_byte(FIRST_BYTE);
      if (ext) begin
         push_byte({1'b1, LEN_EXT16});
         push_byte(len[15:8]);
         push_byte(len[7:0]);
         overhead = 8;
      end else begin
         push_byte({1'b1, len[6:0]});
         overhead = 6;
      end
      if (len == 0 || len + overhead > int'(cur_limit))
         return;
      repeat (4) push_byte(8'($urandom));
      repeat (payload_cnt) push_byte(8'($urandom));
   endtask

   // Mostly well-formed frames of random size, mixed with faults, noise and cut frames
   task automatic random_traffic(input logic [16:0] limit);
      int target;
      int r;
      int len;
      write_limit(limit);
      target = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < target) begin
         calm = ($urandom_range(0, 7) == 0);
         r = $urandom_range(0, 99);
         if (r < 72) begin
            if (r < 36) begin
               len = $urandom_range(0, 8);
               send_frame(len, 1'b0, len);
            end else if (r < 58) begin
               len = $urandom_range(9, 40);
               send_frame(len, 1'b0, len);
            end else if (r < 65) begin
               len = $urandom_range(41, 125);
               send_frame(len, 1'b0, len);
            end else if (r < 70) begin
               len = $urandom_range(0, 300);
               send_frame(len, 1'b1, len);
            end else begin
               len = $urandom_range(126, 600);
               send_frame(len, 1'b1, len);
            end
         end else if (r < 82) begin
            push_byte(FIRST_BYTE);
            case ($urandom_range(0, 2))
               0:       push_byte({1'($urandom), LEN_EXT64});
               1:       push_byte({1'b0, 7'($urandom_range(0, 126))});
               default: push_byte({1'b1, 7'd0});
            endcase
         end else if (r < 92) begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
         end else begin
            len = $urandom_range(2, 20);
            send_frame(len, 1'b0, $urandom_range(1, len - 1));
         end
      end
   endtask

   initial begin
      opening = '{8'h00, 8'hff,                   // bad first bytes
                  8'h82, 8'hff,                   // length 127, masked
                  8'h82, 8'h7f,                   // length 127 and unmasked
                  8'h82, 8'h05,                   // unmasked
                  8'h82, 8'h80,                   // empty
                  8'h82, 8'hfe, 8'h00, 8'h00,     // empty via extended length
                  8'h82, 8'h81, 8'h5a, 8'h00, 8'h00, 8'h00, 8'h0f};  // one-byte frame

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Header faults and key byte order under the reset limit
      foreach (opening[i]) push_byte(opening[i]);

      // Limit of zero: even an empty frame is too large
      write_limit(17'd0);
      push_byte(FIRST_BYTE);
      push_byte(8'h80);
      push_byte(FIRST_BYTE);
      push_byte({1'b1, LEN_EXT16});
      push_byte(8'hff);
      push_byte(8'hff);

      // Smallest useful limit: only one payload byte fits
      write_limit(17'd7);
      send_frame(1, 1'b0, 1);
      send_frame(2, 1'b0, 2);
      send_frame(1, 1'b1, 1);

      // Largest extended length one byte over the limit: rejected at the header
      write_limit(MAX_LEN_RESET - 17'd1);
      send_frame(65535, 1'b1, 65535);

      // Extended-length frame that fills the limit exactly, sent back to back
      write_limit(17'd138);
      calm = 1'b1;
      send_frame(130, 1'b1, 130);
      calm = 1'b0;

      random_traffic(17'($urandom_range(7, 200)));
      random_traffic(17'($urandom_range(201, 2000)));
      random_traffic(LIMIT_TOP);

      // Drain, then let the checker flag anything still owed
      req_valid <= 1'b0;
      calm = 1'b1;
      @(posedge clock);
      while (beats_owed != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      end_check <= 1'b1;
      repeat (3) @(posedge clock);

      $display("Sent %0d bytes across %0d size limits, from 0 to the 17-bit maximum.",
               bytes_sent, limit_writes);
      $display("Checked %0d data beats and %0d error beats; %0d frames ran to their last byte.",
               data_beats, error_beats, frames_closed);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/wsdf_pkg.sv
rtl/wsdf_parser.sv
rtl/wsdf_rsp_buf.sv
rtl/websocket_frame_deframer_unmask.sv
test/wsdf_checker.sv
test/websocket_frame_deframer_unmask_tb.sv
